[design/pwsh_pkg.sv]
package pwsh_pkg;

  localparam int WP_COUNT = 5;
  localparam int WP_W     = 12;
  localparam int CFG_W    = WP_COUNT * WP_W;
  localparam int CFG_IDX_W = 3;

  localparam int SIG_W    = 16;
  localparam int S_DATA_W = 168;
  localparam int S_USER_W = 2;

  localparam int STAGES = 11;

  localparam int MAP_W  = 25;
  localparam int DIFF_W = 26;
  localparam int U_W    = 17;
  localparam int OFF_W  = 17;
  localparam int PROD_W = DIFF_W + OFF_W;
  localparam int DRV_W  = 16;
  localparam int LV_W   = 15;
  localparam int V_W    = 41;
  localparam int P1_W   = 56;
  localparam int D_W    = 30;
  localparam int LVL_W  = 13;
  localparam int M1_W   = 43;
  localparam int M2_W   = 58;
  localparam int Q_W    = 28;
  localparam int N_W    = 19;
  localparam int RCP_W  = 20;
  localparam int T_W    = N_W + RCP_W;
  localparam int O_W    = 18;

  // segment edges on the offset input, Q11 volts
  localparam logic signed [U_W-1:0] U_BIAS = 17'sd10240;
  localparam logic signed [U_W-1:0] U_SEG1 = 17'sd5120;
  localparam logic signed [U_W-1:0] U_SEG2 = 17'sd10240;
  localparam logic signed [U_W-1:0] U_SEG3 = 17'sd15360;

  // 5 V in Q31
  localparam logic signed [V_W-1:0] V_BIAS = 41'sd10737418240;

  localparam logic signed [17:0] DRV_MIN = 18'sd2048;
  localparam logic signed [17:0] DRV_MAX = 18'sd20480;
  localparam logic [LV_W-1:0] LV_FULL = 15'd20480;

  localparam logic signed [P1_W-1:0] P1_RND  = 56'sd33554432;
  localparam logic signed [D_W-1:0]  CLIP_HI = 30'sd655360;
  localparam logic signed [D_W-1:0]  CLIP_LO = -30'sd655360;

  // level scale is 5 * 2^30: shift by 30, then divide by 5
  localparam logic signed [M2_W-1:0] M2_RND = 58'sd2684354560;
  localparam logic signed [Q_W-1:0]  Q_LIM  = 28'sd200000;
  localparam logic [RCP_W-1:0]       RCP5   = 20'd838861;
  localparam int                     RCP_SH = 22;
  localparam logic signed [O_W-1:0]  O_BIAS = 18'sd40000;
  localparam logic signed [O_W-1:0]  O_OFFS = 18'sd5120;
  localparam logic signed [O_W-1:0]  O_MAX  = 18'sd32767;
  localparam logic signed [O_W-1:0]  O_MIN  = -18'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAYPOINTS,
    REG_FIRST_GAINS,
    REG_SECOND_GAINS,
    REG_DRIVE,
    REG_LEVEL,
    REG_HARD_CLIP,
    REG_IN_BIPOLAR,
    REG_OUT_BIPOLAR
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] waypoints;
    logic [CFG_W-1:0] first_cv_gains;
    logic [CFG_W-1:0] second_cv_gains;
    logic [11:0]      drive_setting;
    logic [LVL_W-1:0] level_setting;
    logic             hard_clip_enable;
    logic             input_bipolar;
    logic             output_bipolar;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    waypoints:        60'h800600400200000,
    first_cv_gains:   60'h0,
    second_cv_gains:  60'h0,
    drive_setting:    12'd512,
    level_setting:    13'd2048,
    hard_clip_enable: 1'b1,
    input_bipolar:    1'b0,
    output_bipolar:   1'b0
  };

  typedef logic [STAGES-1:0] stage_en_t;
  typedef logic signed [MAP_W-1:0] map_t;
  typedef map_t [WP_COUNT-1:0] map_vec_t;

endpackage

[design/pwsh_flow.sv]
module pwsh_flow (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 m_tready,
  output pwsh_pkg::stage_en_t  en,
  output logic                 s_tready,
  output logic                 m_tvalid
);

  logic [pwsh_pkg::STAGES-1:0] vld;
  logic [pwsh_pkg::STAGES-1:0] vld_in;

  assign vld_in = {vld[pwsh_pkg::STAGES-2:0], s_tvalid};

  // a stage loads when it is empty or the one after it loads too
  always_comb begin
    en[pwsh_pkg::STAGES-1] = !vld[pwsh_pkg::STAGES-1] || m_tready;
    for (int k = pwsh_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < pwsh_pkg::STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[pwsh_pkg::STAGES-1];

endmodule

[design/pwsh_map.sv]
module pwsh_map (
  input  logic                               clk,
  input  logic                               en,
  input  pwsh_pkg::cfg_t                     cfg,
  input  logic signed [pwsh_pkg::SIG_W-1:0]  signal_in,
  input  logic [pwsh_pkg::CFG_W-1:0]         first_cvs,
  input  logic [pwsh_pkg::CFG_W-1:0]         second_cvs,
  input  logic signed [pwsh_pkg::SIG_W-1:0]  drive_cv,
  input  logic                               drive_cv_present,
  input  logic signed [pwsh_pkg::SIG_W-1:0]  level_cv,
  input  logic                               level_cv_present,
  output pwsh_pkg::map_vec_t                 map,
  output logic signed [pwsh_pkg::U_W-1:0]    u,
  output logic [1:0]                         seg,
  output logic [pwsh_pkg::DRV_W-1:0]         drive,
  output logic [pwsh_pkg::LV_W-1:0]          lv
);

  logic signed [pwsh_pkg::U_W-1:0] u_next;
  logic [1:0]                      seg_next;
  logic signed [17:0]              dsum;
  logic [pwsh_pkg::DRV_W-1:0]      drive_next;
  logic [pwsh_pkg::LV_W-1:0]       lv_next;

  // one lane per waypoint: setting plus two CV products
  for (genvar m = 0; m < pwsh_pkg::WP_COUNT; m++) begin : g_lane
    logic signed [pwsh_pkg::WP_W-1:0]   c1, c2, g1, g2;
    logic signed [2*pwsh_pkg::WP_W-1:0] pa, pb;
    pwsh_pkg::map_t                     wterm;
    pwsh_pkg::map_t                     map_q;

    assign c1 = first_cvs[m*pwsh_pkg::WP_W +: pwsh_pkg::WP_W];
    assign c2 = second_cvs[m*pwsh_pkg::WP_W +: pwsh_pkg::WP_W];
    assign g1 = cfg.first_cv_gains[m*pwsh_pkg::WP_W +: pwsh_pkg::WP_W];
    assign g2 = cfg.second_cv_gains[m*pwsh_pkg::WP_W +: pwsh_pkg::WP_W];
    assign pa = c1 * g1;
    assign pb = c2 * g2;
    assign wterm = signed'({2'b00, cfg.waypoints[m*pwsh_pkg::WP_W +: pwsh_pkg::WP_W], 11'b0});

    always_ff @(posedge clk) begin
      if (en) begin
        map_q <= wterm + pwsh_pkg::MAP_W'(pa) + pwsh_pkg::MAP_W'(pb);
      end
    end

    assign map[m] = map_q;
  end

  always_comb begin
    u_next = pwsh_pkg::U_W'(signal_in) + (cfg.input_bipolar ? pwsh_pkg::U_BIAS : '0);
    priority if (u_next <= pwsh_pkg::U_SEG1) begin
      seg_next = 2'd0;
    end else if (u_next <= pwsh_pkg::U_SEG2) begin
      seg_next = 2'd1;
    end else if (u_next <= pwsh_pkg::U_SEG3) begin
      seg_next = 2'd2;
    end else begin
      seg_next = 2'd3;
    end

    dsum = 18'(drive_cv) + signed'({3'b000, cfg.drive_setting, 3'b000});
    if (!drive_cv_present) begin
      drive_next = pwsh_pkg::DRV_W'({cfg.drive_setting, 3'b000});
    end else if (dsum < pwsh_pkg::DRV_MIN) begin
      drive_next = pwsh_pkg::DRV_W'(pwsh_pkg::DRV_MIN);
    end else if (dsum > pwsh_pkg::DRV_MAX) begin
      drive_next = pwsh_pkg::DRV_W'(pwsh_pkg::DRV_MAX);
    end else begin
      drive_next = dsum[pwsh_pkg::DRV_W-1:0];
    end

    // no level CV means full scale, which folds both level paths into one
    if (!level_cv_present) begin
      lv_next = pwsh_pkg::LV_FULL;
    end else if (level_cv < 0) begin
      lv_next = '0;
    end else if (level_cv > signed'({1'b0, pwsh_pkg::LV_FULL})) begin
      lv_next = pwsh_pkg::LV_FULL;
    end else begin
      lv_next = level_cv[pwsh_pkg::LV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u     <= u_next;
      seg   <= seg_next;
      drive <= drive_next;
      lv    <= lv_next;
    end
  end

endmodule

[design/pwsh_interp.sv]
module pwsh_interp (
  input  logic                               clk,
  input  logic [2:0]                         en,
  input  pwsh_pkg::map_vec_t                 map,
  input  logic signed [pwsh_pkg::U_W-1:0]    u,
  input  logic [1:0]                         seg,
  input  logic [pwsh_pkg::DRV_W-1:0]         drive_in,
  input  logic [pwsh_pkg::LV_W-1:0]          lv_in,
  output logic signed [pwsh_pkg::V_W-1:0]    v,
  output logic [pwsh_pkg::DRV_W-1:0]         drive,
  output logic [pwsh_pkg::LV_W-1:0]          lv
);

  pwsh_pkg::map_t                        lo_pt, hi_pt;
  logic signed [pwsh_pkg::OFF_W-1:0]     off_next;

  pwsh_pkg::map_t                        base;
  logic signed [pwsh_pkg::DIFF_W-1:0]    diff;
  logic signed [pwsh_pkg::OFF_W-1:0]     off;
  logic signed [pwsh_pkg::PROD_W-1:0]    prod;
  logic signed [pwsh_pkg::V_W-1:0]       bterm;
  logic [pwsh_pkg::DRV_W-1:0]            drive2, drive3;
  logic [pwsh_pkg::LV_W-1:0]             lv2, lv3;

  always_comb begin
    lo_pt = map[seg];
    hi_pt = map[{1'b0, seg} + 3'd1];
    unique case (seg)
      2'd0:    off_next = u;
      2'd1:    off_next = u - pwsh_pkg::U_SEG1;
      2'd2:    off_next = u - pwsh_pkg::U_SEG2;
      default: off_next = u - pwsh_pkg::U_SEG3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base   <= lo_pt;
      diff   <= pwsh_pkg::DIFF_W'(hi_pt) - pwsh_pkg::DIFF_W'(lo_pt);
      off    <= off_next;
      drive2 <= drive_in;
      lv2    <= lv_in;
    end
    if (en[1]) begin
      prod   <= diff * off;
      // 5120 * base - 5 V
      bterm  <= (pwsh_pkg::V_W'(base) <<< 12) + (pwsh_pkg::V_W'(base) <<< 10)
                - pwsh_pkg::V_BIAS;
      drive3 <= drive2;
      lv3    <= lv2;
    end
    if (en[2]) begin
      v      <= pwsh_pkg::V_W'(prod) + bterm;
      drive  <= drive3;
      lv     <= lv3;
    end
  end

endmodule

[design/pwsh_gain.sv]
module pwsh_gain (
  input  logic                               clk,
  input  logic [6:0]                         en,
  input  pwsh_pkg::cfg_t                     cfg,
  input  logic signed [pwsh_pkg::V_W-1:0]    v,
  input  logic [pwsh_pkg::DRV_W-1:0]         drive,
  input  logic [pwsh_pkg::LV_W-1:0]          lv_in,
  output logic signed [pwsh_pkg::SIG_W-1:0]  signal_out
);

  logic signed [pwsh_pkg::V_W+pwsh_pkg::DRV_W:0]   p1_full;
  logic signed [pwsh_pkg::P1_W-1:0]                p1_rnd;
  logic signed [pwsh_pkg::D_W-1:0]                 d_raw, d_next;
  logic signed [pwsh_pkg::D_W+pwsh_pkg::LVL_W:0]   m1_full;
  logic signed [pwsh_pkg::M1_W+pwsh_pkg::LV_W:0]   m2_full;
  logic signed [pwsh_pkg::M2_W-1:0]                m2_rnd;
  logic signed [pwsh_pkg::Q_W-1:0]                 q, q_clamped;
  logic signed [pwsh_pkg::O_W-1:0]                 o_sum;

  logic signed [pwsh_pkg::P1_W-1:0]  p1;
  logic signed [pwsh_pkg::D_W-1:0]   d;
  logic signed [pwsh_pkg::M1_W-1:0]  m1;
  logic signed [pwsh_pkg::M2_W-1:0]  m2;
  logic [pwsh_pkg::N_W-1:0]          n;
  logic [pwsh_pkg::T_W-1:0]          t;
  logic [pwsh_pkg::LV_W-1:0]         lv5, lv6, lv7;

  always_comb begin
    p1_full = v * signed'({1'b0, drive});
    p1_rnd  = p1 + pwsh_pkg::P1_RND;
    d_raw   = p1_rnd[pwsh_pkg::P1_W-1:26];
    if (cfg.hard_clip_enable && d_raw > pwsh_pkg::CLIP_HI) begin
      d_next = pwsh_pkg::CLIP_HI;
    end else if (cfg.hard_clip_enable && d_raw < pwsh_pkg::CLIP_LO) begin
      d_next = pwsh_pkg::CLIP_LO;
    end else begin
      d_next = d_raw;
    end

    m1_full = d * signed'({1'b0, cfg.level_setting});
    m2_full = m1 * signed'({1'b0, lv7});

    // floor of the Q30 shift; clamping keeps saturation and bounds the /5
    m2_rnd = m2 + pwsh_pkg::M2_RND;
    q      = m2_rnd[pwsh_pkg::M2_W-1:30];
    if (q > pwsh_pkg::Q_LIM) begin
      q_clamped = pwsh_pkg::Q_LIM;
    end else if (q < -pwsh_pkg::Q_LIM) begin
      q_clamped = -pwsh_pkg::Q_LIM;
    end else begin
      q_clamped = q;
    end

    // divide by 5 through reciprocal, remove the bias, add the output offset unless output is bipolar
    o_sum = signed'({1'b0, t[pwsh_pkg::T_W-1:pwsh_pkg::RCP_SH]}) - pwsh_pkg::O_BIAS
            + (cfg.output_bipolar ? '0 : pwsh_pkg::O_OFFS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1  <= p1_full[pwsh_pkg::P1_W-1:0];
      lv5 <= lv_in;
    end
    if (en[1]) begin
      d   <= d_next;
      lv6 <= lv5;
    end
    if (en[2]) begin
      m1  <= m1_full[pwsh_pkg::M1_W-1:0];
      lv7 <= lv6;
    end
    if (en[3]) begin
      m2  <= m2_full[pwsh_pkg::M2_W-1:0];
    end
    if (en[4]) begin
      n   <= pwsh_pkg::N_W'(q_clamped + pwsh_pkg::Q_LIM);
    end
    if (en[5]) begin
      t   <= n * pwsh_pkg::RCP5;
    end
    if (en[6]) begin
      if (o_sum > pwsh_pkg::O_MAX) begin
        signal_out <= pwsh_pkg::SIG_W'(pwsh_pkg::O_MAX);
      end else if (o_sum < pwsh_pkg::O_MIN) begin
        signal_out <= pwsh_pkg::SIG_W'(pwsh_pkg::O_MIN);
      end else begin
        signal_out <= o_sum[pwsh_pkg::SIG_W-1:0];
      end
    end
  end

endmodule

[design/piecewise_linear_waveshaper.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  sample request, CVs and CV-present flags
// m_*       out  m_tvalid/m_tready  shaped sample
// cfg_*     in   cfg_we             register index and data, no read-back
//
// Eleven register stages; one sample per cycle is sustained while the output is
// not stalled, and the two long multiplies set the depth.
// Each stage holds its data while the next one is full and stalled, so bubbles
// close up and nothing is dropped or repeated under back-pressure.
// rst clears all stage valid bits and returns the registers to their defaults.
module piecewise_linear_waveshaper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // signal_in, first_cvs, second_cvs, drive_cv, level_cv
  input  logic [pwsh_pkg::S_DATA_W-1:0]       s_tdata,
  // drive_cv_present, level_cv_present
  input  logic [pwsh_pkg::S_USER_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // signal_out
  output logic [pwsh_pkg::SIG_W-1:0]          m_tdata,
  input  logic                                cfg_we,
  input  logic [pwsh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwsh_pkg::CFG_W-1:0]          cfg_data
);

  pwsh_pkg::cfg_t                      cfg;
  pwsh_pkg::stage_en_t                 en;

  pwsh_pkg::map_vec_t                  map1;
  logic signed [pwsh_pkg::U_W-1:0]     u1;
  logic [1:0]                          seg1;
  logic [pwsh_pkg::DRV_W-1:0]          drive1, drive4;
  logic [pwsh_pkg::LV_W-1:0]           lv1, lv4;
  logic signed [pwsh_pkg::V_W-1:0]     v4;
  logic signed [pwsh_pkg::SIG_W-1:0]   out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pwsh_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (pwsh_pkg::cfg_reg_t'(cfg_index))
        pwsh_pkg::REG_WAYPOINTS:    cfg.waypoints        <= cfg_data;
        pwsh_pkg::REG_FIRST_GAINS:  cfg.first_cv_gains   <= cfg_data;
        pwsh_pkg::REG_SECOND_GAINS: cfg.second_cv_gains  <= cfg_data;
        pwsh_pkg::REG_DRIVE:        cfg.drive_setting    <= cfg_data[11:0];
        pwsh_pkg::REG_LEVEL:        cfg.level_setting    <= cfg_data[pwsh_pkg::LVL_W-1:0];
        pwsh_pkg::REG_HARD_CLIP:    cfg.hard_clip_enable <= cfg_data[0];
        pwsh_pkg::REG_IN_BIPOLAR:   cfg.input_bipolar    <= cfg_data[0];
        pwsh_pkg::REG_OUT_BIPOLAR:  cfg.output_bipolar   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pwsh_flow u_flow (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .en       (en),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid)
  );

  pwsh_map u_map (
    .clk              (clk),
    .en               (en[0]),
    .cfg              (cfg),
    .signal_in        (s_tdata[15:0]),
    .first_cvs        (s_tdata[75:16]),
    .second_cvs       (s_tdata[135:76]),
    .drive_cv         (s_tdata[151:136]),
    .drive_cv_present (s_tuser[0]),
    .level_cv         (s_tdata[167:152]),
    .level_cv_present (s_tuser[1]),
    .map              (map1),
    .u                (u1),
    .seg              (seg1),
    .drive            (drive1),
    .lv               (lv1)
  );

  pwsh_interp u_interp (
    .clk      (clk),
    .en       (en[3:1]),
    .map      (map1),
    .u        (u1),
    .seg      (seg1),
    .drive_in (drive1),
    .lv_in    (lv1),
    .v        (v4),
    .drive    (drive4),
    .lv       (lv4)
  );

  pwsh_gain u_gain (
    .clk        (clk),
    .en         (en[10:4]),
    .cfg        (cfg),
    .v          (v4),
    .drive      (drive4),
    .lv_in      (lv4),
    .signal_out (out_sample)
  );

  assign m_tdata = out_sample;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pwsh_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 97;
  localparam int TAIL_CYCLES = 3 * STAGES;

  typedef struct {
    logic signed [SIG_W-1:0] sig;
    logic [CFG_W-1:0]        cv1;
    logic [CFG_W-1:0]        cv2;
    logic signed [SIG_W-1:0] drv_cv;
    logic                    drv_on;
    logic signed [SIG_W-1:0] lvl_cv;
    logic                    lvl_on;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [SIG_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  cfg_t shaper_cfg = CFG_RESET;
  sample_t sample_queue[$];
  logic signed [SIG_W-1:0] shaped_queue[$];
  sample_t on_bus;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;

  int n_fail = 0;
  int n_checked = 0;
  int n_settings = 1;
  int input_stalls = 0;

  piecewise_linear_waveshaper dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- shaping math

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // round half up
  function automatic longint round_div(longint a, longint b);
    return floor_div(a + b / 2, b);
  endfunction

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [SIG_W-1:0] shape_sample(cfg_t c, sample_t s);
    longint map_q22[WP_COUNT];
    logic [WP_W-1:0] wp;
    logic signed [WP_W-1:0] c1, c2, g1, g2;
    longint u, v, drive, d, o;
    int seg;
    for (int m = 0; m < WP_COUNT; m++) begin
      wp = c.waypoints[WP_W*m +: WP_W];
      c1 = s.cv1[WP_W*m +: WP_W];
      c2 = s.cv2[WP_W*m +: WP_W];
      g1 = c.first_cv_gains[WP_W*m +: WP_W];
      g2 = c.second_cv_gains[WP_W*m +: WP_W];
      map_q22[m] = longint'(wp) * 2048 + longint'(c1) * longint'(g1)
                 + longint'(c2) * longint'(g2);
    end
    u = longint'(s.sig) + (c.input_bipolar ? 10240 : 0);
    if (u <= 5120) seg = 0;
    else if (u <= 10240) seg = 1;
    else if (u <= 15360) seg = 2;
    else seg = 3;
    // Q31 volts, centered on 5 V
    v = 5120 * map_q22[seg] + (u - 5120 * seg) * (map_q22[seg+1] - map_q22[seg])
      - 64'sd10737418240;
    if (s.drv_on)
      drive = clamp64(longint'(s.drv_cv) + 8 * longint'(c.drive_setting), 2048, 20480);
    else
      drive = 8 * longint'(c.drive_setting);
    d = round_div(v * drive, 64'sd67108864);
    if (c.hard_clip_enable) d = clamp64(d, -655360, 655360);
    if (s.lvl_on)
      o = round_div(d * longint'(c.level_setting) * clamp64(longint'(s.lvl_cv), 0, 20480),
                    64'sd5368709120);
    else
      o = round_div(d * longint'(c.level_setting), 64'sd262144);
    if (!c.output_bipolar) o = o + 5120;
    o = clamp64(o, -32768, 32767);
    return o[SIG_W-1:0];
  endfunction

  // ---------------------------------------------------------------- driver / monitor

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) shaped_queue.push_back(shape_sample(shaper_cfg, on_bus));
      if (s_tvalid && !s_tready) input_stalls++;
      if (!s_tvalid || s_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = sample_queue.pop_front();
          s_tdata <= {on_bus.lvl_cv, on_bus.drv_cv, on_bus.cv2, on_bus.cv1, on_bus.sig};
          s_tuser <= {on_bus.lvl_on, on_bus.drv_on};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [SIG_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (shaped_queue.size() == 0) begin
          $error("signal_out with no request pending: got %0d", $signed(m_tdata));
          n_fail++;
        end else begin
          want = shaped_queue.pop_front();
          n_checked++;
          if (m_tdata !== want) begin
            $error("signal_out mismatch: expected %0d, got %0d", want, $signed(m_tdata));
            n_fail++;
          end
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline fills and backs up into s_tready
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CFG_W-1:0] rand60();
    logic [63:0] x;
    x = {$urandom, $urandom};
    return x[CFG_W-1:0];
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WAYPOINTS:    shaper_cfg.waypoints = data;
      REG_FIRST_GAINS:  shaper_cfg.first_cv_gains = data;
      REG_SECOND_GAINS: shaper_cfg.second_cv_gains = data;
      REG_DRIVE:        shaper_cfg.drive_setting = data[11:0];
      REG_LEVEL:        shaper_cfg.level_setting = data[LVL_W-1:0];
      REG_HARD_CLIP:    shaper_cfg.hard_clip_enable = data[0];
      REG_IN_BIPOLAR:   shaper_cfg.input_bipolar = data[0];
      REG_OUT_BIPOLAR:  shaper_cfg.output_bipolar = data[0];
      default: ;
    endcase
  endtask

  // junk in the unused upper bits checks the width masking
  task automatic apply_config(input cfg_t c);
    logic [CFG_W-1:0] junk;
    junk = rand60();
    write_reg(REG_WAYPOINTS, c.waypoints);
    write_reg(REG_FIRST_GAINS, c.first_cv_gains);
    write_reg(REG_SECOND_GAINS, c.second_cv_gains);
    write_reg(REG_DRIVE, {junk[CFG_W-13:0], c.drive_setting});
    write_reg(REG_LEVEL, {junk[CFG_W-LVL_W-1:0], c.level_setting});
    write_reg(REG_HARD_CLIP, {junk[CFG_W-2:0], c.hard_clip_enable});
    write_reg(REG_IN_BIPOLAR, {junk[CFG_W-1:1], c.input_bipolar});
    write_reg(REG_OUT_BIPOLAR, {junk[CFG_W-2:0] ^ 59'h5, c.output_bipolar});
    n_settings++;
  endtask

  function automatic cfg_t rand_config(int k);
    cfg_t c;
    case (k % 4)
      0: c.waypoints = '0;
      1: c.waypoints = rand60();
      default: begin
        for (int m = 0; m < WP_COUNT; m++)
          c.waypoints[WP_W*m +: WP_W] = WP_W'($urandom_range(2048));
      end
    endcase
    c.first_cv_gains = ($urandom_range(2) == 0) ? '0 : rand60();
    c.second_cv_gains = ($urandom_range(2) == 0) ? '0 : rand60();
    case (k % 5)
      0: begin c.drive_setting = 12'd256;  c.level_setting = '0; end
      1: begin c.drive_setting = 12'd2560; c.level_setting = 13'd4096; end
      2: begin
        c.drive_setting = 12'($urandom);
        c.level_setting = LVL_W'($urandom);
      end
      default: begin
        c.drive_setting = 12'($urandom_range(2560, 256));
        c.level_setting = LVL_W'($urandom_range(4096));
      end
    endcase
    c.hard_clip_enable = 1'($urandom_range(1));
    c.input_bipolar = 1'($urandom_range(1));
    c.output_bipolar = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic add_sample(input logic signed [SIG_W-1:0] sig, input logic [CFG_W-1:0] cv1,
                            input logic [CFG_W-1:0] cv2, input logic signed [SIG_W-1:0] dcv,
                            input logic don, input logic signed [SIG_W-1:0] lcv,
                            input logic lon);
    sample_t s;
    s.sig = sig;
    s.cv1 = cv1;
    s.cv2 = cv2;
    s.drv_cv = dcv;
    s.drv_on = don;
    s.lvl_cv = lcv;
    s.lvl_on = lon;
    sample_queue.push_back(s);
  endtask

  function automatic sample_t rand_sample(logic bipolar);
    sample_t s;
    int edge_u;
    case ($urandom_range(3))
      0: s.sig = SIG_W'($urandom);
      1: s.sig = SIG_W'(int'($urandom_range(30720)) - 10240);
      2: begin
        // land on or next to a segment boundary
        edge_u = 5120 * int'($urandom_range(3, 1)) + int'($urandom_range(4)) - 2;
        s.sig = SIG_W'(edge_u - (bipolar ? 10240 : 0));
      end
      default: s.sig = SIG_W'(int'($urandom_range(20480)) - 10240);
    endcase
    s.cv1 = ($urandom_range(3) == 0) ? '0 : rand60();
    s.cv2 = ($urandom_range(3) == 0) ? '0 : rand60();
    s.drv_cv = ($urandom_range(1) == 0) ? SIG_W'($urandom)
                                        : SIG_W'(int'($urandom_range(20480)) - 10240);
    s.drv_on = 1'($urandom_range(1));
    s.lvl_cv = ($urandom_range(2) == 0) ? SIG_W'($urandom) : SIG_W'($urandom_range(20480));
    s.lvl_on = 1'($urandom_range(1));
    return s;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || shaped_queue.size() != 0);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic directed_samples();
    @(negedge clk);
    add_sample(-16'sd32768, '1, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
    add_sample(16'sd32767, 60'h7FF7FF7FF7FF7FF, 60'h800800800800800,
               16'sd32767, 1'b1, 16'sd32767, 1'b1);
    add_sample(16'sd0, 60'h800800800800800, 60'h7FF7FF7FF7FF7FF,
               -16'sd32768, 1'b1, -16'sd32768, 1'b1);
    add_sample(16'sd5120, '1, '1, 16'sd0, 1'b1, 16'sd20480, 1'b1);
    add_sample(16'sd5121, 60'h001001001001001, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
    add_sample(16'sd10240, '0, 60'hFFF000FFF000FFF, -16'sd4096, 1'b1, 16'sd0, 1'b1);
    add_sample(16'sd10241, '0, '0, 16'sd16384, 1'b1, 16'sd20481, 1'b1);
    add_sample(16'sd15360, '1, '0, 16'sd0, 1'b0, 16'sd0, 1'b0);
    add_sample(16'sd15361, '0, '1, 16'sd0, 1'b0, 16'sd0, 1'b0);
    add_sample(-16'sd10240, 60'h7FF7FF7FF7FF7FF, '0, 16'sd2048, 1'b1, 16'sd0, 1'b0);
    add_sample(16'sd20480, '0, 60'h7FF7FF7FF7FF7FF, 16'sd0, 1'b0, 16'sd10240, 1'b1);
    add_sample(-16'sd1, 60'h123456789ABCDEF, 60'hFEDCBA987654321,
               -16'sd20000, 1'b1, 16'sd1, 1'b1);
    wait_drained();
  endtask

  initial begin
    cfg_t c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed set against reset settings, then against extreme settings
    directed_samples();
    c.waypoints = '1;
    c.first_cv_gains = 60'h8007FF8007FF800;
    c.second_cv_gains = 60'h7FF8007FF8007FF;
    c.drive_setting = 12'hFFF;
    c.level_setting = 13'h1FFF;
    c.hard_clip_enable = 1'b0;
    c.input_bipolar = 1'b1;
    c.output_bipolar = 1'b1;
    apply_config(c);
    directed_samples();

    for (int p = 0; p < PHASES; p++) begin
      apply_config(rand_config(p));
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(74, 0);
        2: set_idling(0, 74);
        default: set_idling(33, 33);
      endcase
      if (p == 6) begin
        // sender keeps offering while the receiver is held off
        set_idling(0, 0);
        hold_go = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 9 && i == PHASE_ITEMS / 2) wait_drained();
        sample_queue.push_back(rand_sample(shaper_cfg.input_bipolar));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("shaped %0d samples across %0d register settings and four idle mixes",
             n_checked, n_settings);
    $display("input back-pressure seen on %0d cycles, including one long output hold-off",
             input_stalls);
    if (n_fail == 0 && shaped_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
